// ----- hw/rtl/mpsa_pkg.sv -----
// Package for the multi-pool slot allocator: sizes, command and status
// codes, register indexes and the sequencer state type.
// Depends on nothing; imported by multi_pool_slot_allocator.
package mpsa_pkg;

   localparam int NUM_POOLS      = 11;
   localparam int SLOTS_PER_POOL = 64;

   // Pool memory index width and the widths fixed by the request format.
   localparam int POOL_IDX_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int POOL_ID_W  = 4;
   localparam int SLOT_W     = 6;
   localparam int LIMIT_W    = 7;
   localparam int SEARCH_W   = 64;
   localparam int GROUP_W    = 8;
   localparam int GROUPS     = SEARCH_W / GROUP_W;

   localparam int       REG_COUNT   = 3;
   localparam int       CSR_ADDR_W  = 4;
   localparam int       CSR_DATA_W  = 32;
   localparam logic [31:0] LIMIT_RESET = 32'h4040_4040;

   localparam logic [1:0] REG_LIMITS_0_3  = 2'd0;
   localparam logic [1:0] REG_LIMITS_4_7  = 2'd1;
   localparam logic [1:0] REG_LIMITS_8_11 = 2'd2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

// ----- hw/rtl/multi_pool_slot_allocator.sv -----
// Multi-pool slot allocator: occupancy bitmaps in one synchronous memory,
// limit registers on an APB-style port, at most one read-modify-write per request.
// Depends on mpsa_pkg.

// Each request is handled in steps: the cycle in which it is accepted
// issues the read of its pool's bitmap word from the occupancy memory, and
// the next cycle searches that word for the lowest free slot below the
// pool's limit (or clears the named slot), writes the word back and loads
// the result register. A new request is taken in the cycle after that, while
// the previous result may still wait in the result register; if that result
// has not been taken, the block holds the search-and-write-back step until it has. After
// reset the block is ready at once: a per-pool valid bit makes an unwritten
// bitmap read as all slots free, so no clearing pass is needed.
module multi_pool_slot_allocator
   import mpsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [POOL_ID_W-1:0]  req_pool_id,
   input  logic [SLOT_W-1:0]     req_slot_to_free,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SLOT_W-1:0]     rsp_slot_index,
   output logic                  rsp_status,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] limits_ff [REG_COUNT];

   logic [SLOTS_PER_POOL-1:0] occ_mem [NUM_POOLS];
   logic [NUM_POOLS-1:0]      word_valid_ff;
   logic [SLOTS_PER_POOL-1:0] rd_word_ff;
   logic                      rd_valid_ff;

   logic                 cmd_ff;
   logic [POOL_ID_W-1:0] pool_ff;
   logic [SLOT_W-1:0]    slot_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_status_ff;

   logic req_accept;
   logic finish;
   logic csr_write;
   logic req_pool_ok;
   logic pool_ok;

   logic [SLOTS_PER_POOL-1:0] cur_word;
   logic [CSR_DATA_W-1:0]     lim_word;
   logic [7:0]                lim_byte;
   logic [LIMIT_W-1:0]        lim_sat;
   logic [SEARCH_W-1:0]       avail;
   logic [GROUPS-1:0]         grp_any;
   logic [$clog2(GROUPS)-1:0] grp_sel;
   logic [GROUP_W-1:0]        grp_bits;
   logic [$clog2(GROUP_W)-1:0] bit_sel;
   logic                      found;
   logic [SLOT_W-1:0]         found_idx;
   logic                      slot_ok;
   logic                      mem_we;
   logic [SLOTS_PER_POOL-1:0] wr_word;
   logic [SLOT_W-1:0]         res_slot;
   logic                      res_status;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            limits_ff[i] <= LIMIT_RESET;
         end
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_LIMITS_0_3:  limits_ff[0] <= csr_pwdata;
            REG_LIMITS_4_7:  limits_ff[1] <= csr_pwdata;
            REG_LIMITS_8_11: limits_ff[2] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_LIMITS_0_3:  csr_prdata = limits_ff[0];
         REG_LIMITS_4_7:  csr_prdata = limits_ff[1];
         REG_LIMITS_8_11: csr_prdata = limits_ff[2];
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      req_accept   = 1'b0;
      finish       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            req_accept = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // The result register must be free before the request retires.
            if (!rsp_valid_ff || !rsp_stall) begin
               finish       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= req_command;
         pool_ff <= req_pool_id;
         slot_ff <= req_slot_to_free;
      end
   end

   // ---------------------------------------------------------------------
   // Occupancy memory with per-pool valid bits
   // ---------------------------------------------------------------------
   assign req_pool_ok = (req_pool_id < POOL_ID_W'(NUM_POOLS));
   assign pool_ok     = (pool_ff < POOL_ID_W'(NUM_POOLS));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         occ_mem[pool_ff[POOL_IDX_W-1:0]] <= wr_word;
      end
      if (req_accept && req_pool_ok) begin
         rd_word_ff <= occ_mem[req_pool_id[POOL_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (mem_we) begin
            word_valid_ff[pool_ff[POOL_IDX_W-1:0]] <= 1'b1;
         end
         if (req_accept) begin
            rd_valid_ff <= req_pool_ok && word_valid_ff[req_pool_id[POOL_IDX_W-1:0]];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Search and update
   // ---------------------------------------------------------------------
   assign cur_word = rd_valid_ff ? rd_word_ff : '0;

   always_comb begin
      unique case (pool_ff[3:2])
         REG_LIMITS_0_3:  lim_word = limits_ff[0];
         REG_LIMITS_4_7:  lim_word = limits_ff[1];
         REG_LIMITS_8_11: lim_word = limits_ff[2];
         default:         lim_word = limits_ff[0];
      endcase
      lim_byte = lim_word[8*pool_ff[1:0] +: 8];
      if (lim_byte > 8'(SLOTS_PER_POOL)) begin
         lim_sat = LIMIT_W'(SLOTS_PER_POOL);
      end else begin
         lim_sat = lim_byte[LIMIT_W-1:0];
      end
   end

   always_comb begin
      avail = '0;
      for (int k = 0; k < SLOTS_PER_POOL; k++) begin
         avail[k] = !cur_word[k] && (LIMIT_W'(k) < lim_sat);
      end
   end

   // Lowest free slot: pick the lowest non-empty byte group, then the lowest
   // bit inside it.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any[g] = |avail[g*GROUP_W +: GROUP_W];
      end
      grp_sel = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            grp_sel = ($clog2(GROUPS))'(g);
         end
      end
      grp_bits = avail[grp_sel*GROUP_W +: GROUP_W];
      bit_sel  = '0;
      for (int b = GROUP_W - 1; b >= 0; b--) begin
         if (grp_bits[b]) begin
            bit_sel = ($clog2(GROUP_W))'(b);
         end
      end
      found     = |grp_any;
      found_idx = {grp_sel, bit_sel};
   end

   assign slot_ok = ({1'b0, slot_ff} < LIMIT_W'(SLOTS_PER_POOL));

   always_comb begin
      wr_word    = cur_word;
      res_slot   = '0;
      res_status = STATUS_FULL;
      mem_we     = 1'b0;
      unique case (cmd_ff)
         CMD_ALLOC: begin
            if (pool_ok && found) begin
               wr_word[found_idx[$clog2(SLOTS_PER_POOL > 1 ? SLOTS_PER_POOL : 2)-1:0]] = 1'b1;
               res_slot   = found_idx;
               res_status = STATUS_DONE;
               mem_we     = finish;
            end
         end
         CMD_FREE: begin
            res_slot   = slot_ff;
            res_status = STATUS_DONE;
            if (pool_ok && slot_ok) begin
               wr_word[slot_ff[$clog2(SLOTS_PER_POOL > 1 ? SLOTS_PER_POOL : 2)-1:0]] = 1'b0;
               mem_we = finish;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_slot_ff   <= res_slot;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_accept_starts_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter the update cycle");

   a_result_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result appeared without an update cycle");

   a_grant_below_limit: assert property (@(posedge clock) disable iff (reset)
      (finish && cmd_ff == CMD_ALLOC && res_status == STATUS_DONE)
         |-> ({1'b0, found_idx} < lim_sat) && !cur_word[found_idx])
      else $error("granted slot is occupied or not below the pool limit");

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> word_valid_ff[$past(pool_ff[POOL_IDX_W-1:0])])
      else $error("written pool word not marked valid");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_EXEC) && pool_ok)
      else $error("bitmap write outside an update cycle or to a missing pool");

endmodule
